// File: src/tbsg_pkg.sv
// ----------------------------------------------------------------------------
// tbsg_pkg
// Shared types and constants for the three-band spectral gain block.
// ----------------------------------------------------------------------------
package tbsg_pkg;

  // Number of bins the transform delivers; caps the active window.
  localparam int BIN_COUNT = 4096;

  localparam int BIN_W  = 12;
  localparam int FREQ_W = 20;
  localparam int MAG_W  = 24;
  localparam int GAIN_W = 16;
  localparam int RESP_W = 17;   // Q1.16, 65536 = 1.0

  localparam logic [BIN_W-1:0] BIN_LAST = BIN_W'(BIN_COUNT - 1);

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] CFG_LOW_GAIN  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MID_GAIN  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_HIGH_GAIN = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_FIRST_BIN = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_LAST_BIN  = 3'd4;

  // Pipeline depth (register stages, last one is the output register)
  localparam int STAGES = 6;

  typedef struct packed {
    logic [BIN_W-1:0]  bin_index;
    logic [FREQ_W-1:0] bin_frequency;
    logic [MAG_W-1:0]  magnitude_in;
  } in_beat_t;

  typedef struct packed {
    logic [BIN_W-1:0] bin_number;
    logic [MAG_W-1:0] magnitude_out;
    logic             saturated;
  } out_beat_t;

  // Per-stage load enables from the pipeline control
  typedef struct packed {
    logic [STAGES-1:0] load;
  } pipe_ctl_t;

endpackage

// File: src/tbsg_pipe_ctl.sv
// ----------------------------------------------------------------------------
// tbsg_pipe_ctl
// Valid chain and per-stage load enables; bubbles collapse under stall.
// ----------------------------------------------------------------------------
module tbsg_pipe_ctl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output tbsg_pkg::pipe_ctl_t ctl
);
  import tbsg_pkg::*;

  logic [STAGES-1:0] v_r;
  logic [STAGES-1:0] v_nxt;
  logic [STAGES-1:0] load;

  // A stage loads when it is empty or its contents move on.
  always_comb begin
    load[STAGES-1] = !v_r[STAGES-1] || out_ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      load[k] = !v_r[k] || load[k+1];
    end
    v_nxt[0] = load[0] ? in_valid : v_r[0];
    for (int k = 1; k < STAGES; k++) begin
      v_nxt[k] = load[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign ctl.load  = load;
  assign in_ready  = load[0];
  assign out_valid = v_r[STAGES-1];

  // Beats in flight change only by what enters and leaves.
  a_beat_count: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> $countones(v_r) == $past($countones(v_r))
             + int'($past(in_valid && in_ready))
             - int'($past(out_valid && out_ready)))
    else $error("beat count mismatch in pipeline");

  // Input back-pressure only when every stage holds a beat.
  a_full_only: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&v_r))
    else $error("input stalled with a bubble in the pipeline");

  // A held stage keeps its beat.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[0] && !load[1]) |=> v_r[0])
    else $error("stalled beat dropped");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (v_r == '0))
    else $error("pipeline not empty after reset");

endmodule

// File: src/three_band_spectral_gain.sv
// ----------------------------------------------------------------------------
// three_band_spectral_gain
// Per-bin spectral weighting by three overlapping low/mid/high band gains.
// ----------------------------------------------------------------------------
// Streaming bin weigher: returns one beat per beat, in order, through six
// register stages, the last being the output register. Sustained rate is one
// bin per clock; a stall on the output fills any bubbles before the input is
// held off. The band responses come from the bin frequency (Q16.4 Hz): low
// is 1.0 below 200 Hz falling to 0 at 250 Hz, high rises from 0 at 1900 Hz
// to 1.0 at 2000 Hz, mid is the rest. Gains are unsigned Q4.12; the user
// must write them through the cfg_ port only while the block is idle, not
// enforced by the block. Bins outside first_bin..last_bin pass unchanged
// with saturated low; an empty window (first_bin > last_bin) weighs nothing.
// ----------------------------------------------------------------------------
module three_band_spectral_gain (
  input  logic                                clk,
  input  logic                                rst_n,
  // input bins
  input  logic                                in_valid,
  output logic                                in_ready,
  input  tbsg_pkg::in_beat_t                  in_beat,
  // weighted bins
  output logic                                out_valid,
  input  logic                                out_ready,
  output tbsg_pkg::out_beat_t                 out_beat,
  // configuration
  input  logic                                cfg_we,
  input  logic [tbsg_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [tbsg_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import tbsg_pkg::*;

  // Ramp knees and spans in raw Q16.4 units
  localparam logic [FREQ_W-1:0] F_LOW_KNEE  = 20'd3200;   // 200 Hz
  localparam logic [FREQ_W-1:0] F_LOW_END   = 20'd4000;   // 250 Hz
  localparam logic [FREQ_W-1:0] F_HIGH_KNEE = 20'd30400;  // 1900 Hz
  localparam logic [FREQ_W-1:0] F_HIGH_END  = 20'd32000;  // 2000 Hz
  localparam int LOW_D_W  = 10;   // offset below 800
  localparam int HIGH_D_W = 11;   // offset below 1600
  // ceil(2^26/25): floor(x/25) == (x*RECIP_25) >> 26, exact for x < 2^21.
  // low ramp  = d*2048/25 -> (d*RECIP_25) >> 15
  // high ramp = d*1024/25 -> (d*RECIP_25) >> 16
  localparam logic [21:0] RECIP_25 = 22'd2684355;
  localparam logic [RESP_W-1:0] ONE_Q16 = 17'd65536;
  localparam int PROD_W = MAG_W + 32;
  localparam logic [MAG_W-1:0] MAG_MAX = '1;

  typedef struct packed {
    logic [BIN_W-1:0] idx;
    logic [MAG_W-1:0] mag;
    logic             win;
  } side_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [GAIN_W-1:0] low_gain_r, mid_gain_r, high_gain_r;
  logic [BIN_W-1:0]  first_bin_r, last_bin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_gain_r  <= 16'd4096;
      mid_gain_r  <= 16'd4096;
      high_gain_r <= 16'd4096;
      first_bin_r <= '0;
      last_bin_r  <= '1;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_LOW_GAIN:  low_gain_r  <= cfg_data;
        CFG_MID_GAIN:  mid_gain_r  <= cfg_data;
        CFG_HIGH_GAIN: high_gain_r <= cfg_data;
        CFG_FIRST_BIN: first_bin_r <= cfg_data[BIN_W-1:0];
        CFG_LAST_BIN:  last_bin_r  <= cfg_data[BIN_W-1:0];
        default: ;     // unknown index: ignored
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake / stage enables
  // --------------------------------------------------------------------------
  pipe_ctl_t ctl;

  tbsg_pipe_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl)
  );

  // Side data (index, raw magnitude, window flag) rides along stages 0..4
  side_t side_r [STAGES-1];
  side_t side_nxt;

  // --------------------------------------------------------------------------
  // Stage 0: window test, ramp offsets, reciprocal multiply
  // --------------------------------------------------------------------------
  logic [BIN_W-1:0]  top_bin;
  logic [FREQ_W-1:0] d_low, d_high;
  logic              low_zero_r, low_full_r, high_zero_r, high_full_r;
  logic [31:0]       ql_r, ql_nxt;
  logic [32:0]       qh_r, qh_nxt;

  always_comb begin
    // effective last bin never beyond the transform size
    top_bin = (32'(last_bin_r) > BIN_COUNT - 1) ? BIN_LAST : last_bin_r;
    side_nxt.idx = in_beat.bin_index;
    side_nxt.mag = in_beat.magnitude_in;
    side_nxt.win = (in_beat.bin_index >= first_bin_r) && (in_beat.bin_index <= top_bin);
    d_low  = in_beat.bin_frequency - F_LOW_KNEE;
    d_high = in_beat.bin_frequency - F_HIGH_KNEE;
    ql_nxt = 32'(d_low[LOW_D_W-1:0]) * 32'(RECIP_25);
    qh_nxt = 33'(d_high[HIGH_D_W-1:0]) * 33'(RECIP_25);
  end

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      side_r[0]   <= side_nxt;
      low_zero_r  <= in_beat.bin_frequency <= F_LOW_KNEE;
      low_full_r  <= in_beat.bin_frequency >= F_LOW_END;
      high_zero_r <= in_beat.bin_frequency <= F_HIGH_KNEE;
      high_full_r <= in_beat.bin_frequency >= F_HIGH_END;
      ql_r        <= ql_nxt;
      qh_r        <= qh_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: clamp ramps, form low / mid / high responses (Q1.16)
  // --------------------------------------------------------------------------
  logic [RESP_W-1:0] ramp_l, ramp_h;
  logic [RESP_W-1:0] low_r, mid_r, high_r;

  always_comb begin
    if (low_zero_r) begin
      ramp_l = '0;
    end else if (low_full_r) begin
      ramp_l = ONE_Q16;
    end else begin
      ramp_l = ql_r[31:15];
    end
    if (high_zero_r) begin
      ramp_h = '0;
    end else if (high_full_r) begin
      ramp_h = ONE_Q16;
    end else begin
      ramp_h = qh_r[32:16];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      side_r[1] <= side_r[0];
      low_r     <= ONE_Q16 - ramp_l;
      high_r    <= ramp_h;
      // 1 - low - high == ramp_l - ramp_h, floored at zero
      mid_r     <= (ramp_l > ramp_h) ? ramp_l - ramp_h : '0;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: band response times band gain
  // --------------------------------------------------------------------------
  logic [32:0] wl_r, wm_r, wh_r;

  always_ff @(posedge clk) begin
    if (ctl.load[2]) begin
      side_r[2] <= side_r[1];
      wl_r      <= 33'(low_r)  * 33'(low_gain_r);
      wm_r      <= 33'(mid_r)  * 33'(mid_gain_r);
      wh_r      <= 33'(high_r) * 33'(high_gain_r);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: combined gain, Q5.28. The three responses sum to exactly 1.0,
  // so the total stays below 2^32.
  // --------------------------------------------------------------------------
  logic [33:0] gain_sum;
  logic [31:0] gain_r;

  assign gain_sum = 34'(wl_r) + 34'(wm_r) + 34'(wh_r);

  always_ff @(posedge clk) begin
    if (ctl.load[3]) begin
      side_r[3] <= side_r[2];
      gain_r    <= gain_sum[31:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: magnitude times gain
  // --------------------------------------------------------------------------
  logic [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (ctl.load[4]) begin
      side_r[4] <= side_r[3];
      prod_r    <= PROD_W'(side_r[3].mag) * PROD_W'(gain_r);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: truncate by 2^28, saturate, bypass outside the window
  // --------------------------------------------------------------------------
  logic      clip;
  out_beat_t out_nxt;
  out_beat_t out_r;

  always_comb begin
    clip = side_r[4].win && (prod_r[PROD_W-1:28+MAG_W] != '0);
    out_nxt.bin_number = side_r[4].idx;
    out_nxt.saturated  = clip;
    if (!side_r[4].win) begin
      out_nxt.magnitude_out = side_r[4].mag;
    end else if (clip) begin
      out_nxt.magnitude_out = MAG_MAX;
    end else begin
      out_nxt.magnitude_out = prod_r[28+MAG_W-1:28];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load[STAGES-1]) begin
      out_r <= out_nxt;
    end
  end

  assign out_beat = out_r;

endmodule
